### hdl/sva_pkg.sv
// shared constants for the voice allocator
`default_nettype none
package sva_pkg;

  localparam int VOICES_DEF     = 8;
  localparam int LEVEL_BITS_DEF = 16;

  localparam int OPCODE_W = 2;
  localparam int SEL_W    = 3;
  localparam int MIDI_W   = 7;
  localparam int ENV_W    = 16;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  localparam logic [OPCODE_W-1:0] OP_TRIGGER = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_RELEASE = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_REPORT  = 2'd2;

  localparam logic [STATUS_W-1:0] ST_FREE_GRANT = 3'd0;
  localparam logic [STATUS_W-1:0] ST_STOLEN     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DROPPED    = 3'd2;
  localparam logic [STATUS_W-1:0] ST_RELEASED   = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FREED      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_UPDATED    = 3'd5;
  localparam logic [STATUS_W-1:0] ST_IGNORED    = 3'd6;

endpackage
`default_nettype wire

### hdl/sva_voice_cell.sv
// one voice slot: holds the voice flags and level, updates and forwards the scan token
`default_nettype none
module sva_voice_cell
  import sva_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int IDX_W      = 3,
  parameter int CNT_W      = 4,
  parameter int LEVEL_BITS = LEVEL_BITS_DEF,
  parameter type tok_t     = logic,
  parameter type cmd_t     = logic
) (
  input  wire  clk,
  input  wire  rst,
  input  cmd_t cmd,
  input  tok_t tok_in,
  output tok_t tok_out
);

  logic                  en;
  logic                  rl;
  logic [LEVEL_BITS-1:0] lv;
  logic                  en_next;
  logic                  rl_next;
  logic [LEVEL_BITS-1:0] lv_next;
  tok_t                  tok_next;
  logic                  sel_hit;

  assign sel_hit = (int'(cmd.sel) == INDEX);

  always_comb begin
    en_next  = en;
    rl_next  = rl;
    lv_next  = lv;
    tok_next = tok_in;
    if (tok_in.valid) begin
      case (cmd.op)
        OP_TRIGGER: begin
          if (!en && !tok_in.found) begin
            en_next         = 1'b1;
            rl_next         = 1'b0;
            lv_next         = '0;
            tok_next.found  = 1'b1;
            tok_next.voice  = IDX_W'(INDEX);
            tok_next.status = ST_FREE_GRANT;
          end else if (en && rl && (!tok_in.cand || lv <= tok_in.best_lvl)) begin
            tok_next.cand     = 1'b1;
            tok_next.best_idx = IDX_W'(INDEX);
            tok_next.best_lvl = lv;
          end
        end
        OP_RELEASE: begin
          if (sel_hit && en) begin
            rl_next         = 1'b1;
            tok_next.found  = 1'b1;
            tok_next.voice  = IDX_W'(INDEX);
            tok_next.status = ST_RELEASED;
          end
        end
        OP_REPORT: begin
          if (sel_hit && en) begin
            lv_next        = cmd.lvl;
            tok_next.found = 1'b1;
            tok_next.voice = IDX_W'(INDEX);
            if (cmd.idle) begin
              en_next         = 1'b0;
              rl_next         = 1'b0;
              tok_next.status = ST_FREED;
            end else begin
              tok_next.status = ST_UPDATED;
            end
          end
        end
        default: begin
        end
      endcase
      tok_next.act = tok_in.act + CNT_W'(en_next);
      tok_next.rel = tok_in.rel + CNT_W'(en_next & rl_next);
    end
    // steal commit after the scan has finished
    if (cmd.steal && cmd.steal_idx == IDX_W'(INDEX)) begin
      en_next = 1'b1;
      rl_next = 1'b0;
      lv_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      en      <= 1'b0;
      rl      <= 1'b0;
      lv      <= '0;
      tok_out <= '0;
    end else begin
      en      <= en_next;
      rl      <= rl_next;
      lv      <= lv_next;
      tok_out <= tok_next;
    end
  end

endmodule
`default_nettype wire

### hdl/synth_voice_allocator_with_stealing_unit.sv
// voice allocator top level: event capture, cell chain, steal commit and result register
// Each accepted event sends a scan token down a chain of VOICES cells, one cell per cycle;
// every cell applies the event to its own voice and adds to the running counts. A trigger
// takes the first free voice on the way; if none is free, the quietest releasing voice
// (highest index on a tie) is stolen in the cycle after the token leaves the chain. The result
// is presented once the token has rippled through the chain (and the steal state, if any, has
// passed). A new event is taken only once the previous result has entered the output register;
// the result may wait there while the next one is scanned.
`default_nettype none
module synth_voice_allocator_with_stealing_unit
  import sva_pkg::*;
#(
  parameter int VOICES     = VOICES_DEF,
  parameter int LEVEL_BITS = LEVEL_BITS_DEF
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  wire  [OPCODE_W-1:0] opcode,
  input  wire  [SEL_W-1:0]    voice_sel,
  input  wire  [MIDI_W-1:0]   note_key,
  input  wire  [MIDI_W-1:0]   note_velocity,
  input  wire  [ENV_W-1:0]    env_level,
  input  wire                 env_idle,
  output logic                out_valid,
  input  wire                 out_stall,
  output logic [STATUS_W-1:0] status,
  output logic [SEL_W-1:0]    granted_voice,
  output logic [MIDI_W-1:0]   out_key,
  output logic [MIDI_W-1:0]   out_velocity,
  output logic [COUNT_W-1:0]  active_count,
  output logic [COUNT_W-1:0]  releasing_count
);

  localparam int IDX_W = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int CNT_W = $clog2(VOICES + 1);

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_STEAL = 2'd2;
  localparam logic [1:0] S_OUT   = 2'd3;

  typedef struct packed {
    logic                  valid;
    logic                  found;
    logic [IDX_W-1:0]      voice;
    logic [STATUS_W-1:0]   status;
    logic                  cand;
    logic [IDX_W-1:0]      best_idx;
    logic [LEVEL_BITS-1:0] best_lvl;
    logic [CNT_W-1:0]      act;
    logic [CNT_W-1:0]      rel;
  } voice_tok_t;

  typedef struct packed {
    logic [OPCODE_W-1:0]   op;
    logic [SEL_W-1:0]      sel;
    logic [LEVEL_BITS-1:0] lvl;
    logic                  idle;
    logic                  steal;
    logic [IDX_W-1:0]      steal_idx;
  } voice_cmd_t;

  logic [1:0]            state;
  logic [1:0]            state_next;
  logic [OPCODE_W-1:0]   op_hold;
  logic [SEL_W-1:0]      sel_hold;
  logic [MIDI_W-1:0]     key_hold;
  logic [MIDI_W-1:0]     vel_hold;
  logic [LEVEL_BITS-1:0] lvl_hold;
  logic                  idle_hold;
  logic                  inject;
  voice_tok_t            fin;
  voice_tok_t            fin_next;
  voice_tok_t            chain [VOICES+1];
  voice_cmd_t            cmd;
  logic                  in_xfer;
  logic                  out_load;
  logic                  granted;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);
  assign granted  = (fin.status == ST_FREE_GRANT) || (fin.status == ST_STOLEN);

  assign chain[0] = '{valid: inject, status: ST_IGNORED, default: '0};

  always_comb begin
    cmd.op        = op_hold;
    cmd.sel       = sel_hold;
    cmd.lvl       = lvl_hold;
    cmd.idle      = idle_hold;
    cmd.steal     = (state == S_STEAL);
    cmd.steal_idx = fin.best_idx;
  end

  for (genvar i = 0; i < VOICES; i++) begin : g_cell
    sva_voice_cell #(
      .INDEX      (i),
      .IDX_W      (IDX_W),
      .CNT_W      (CNT_W),
      .LEVEL_BITS (LEVEL_BITS),
      .tok_t      (voice_tok_t),
      .cmd_t      (voice_cmd_t)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  always_comb begin
    state_next = state;
    fin_next   = fin;
    unique case (state)
      S_IDLE: begin
        if (in_xfer) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (chain[VOICES].valid) begin
          fin_next   = chain[VOICES];
          state_next = S_OUT;
          if (op_hold == OP_TRIGGER && !chain[VOICES].found) begin
            if (chain[VOICES].cand) begin
              state_next = S_STEAL;
            end else begin
              fin_next.status = ST_DROPPED;
              fin_next.voice  = '0;
            end
          end
        end
      end
      S_STEAL: begin
        fin_next.found  = 1'b1;
        fin_next.status = ST_STOLEN;
        fin_next.voice  = fin.best_idx;
        fin_next.rel    = fin.rel - CNT_W'(1);
        state_next      = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      inject    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      inject <= in_xfer;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    fin <= fin_next;
    if (in_xfer) begin
      op_hold   <= opcode;
      sel_hold  <= voice_sel;
      key_hold  <= note_key;
      vel_hold  <= note_velocity;
      lvl_hold  <= LEVEL_BITS'(env_level);
      idle_hold <= env_idle;
    end
    if (out_load) begin
      status          <= fin.status;
      granted_voice   <= SEL_W'(fin.voice);
      out_key         <= granted ? key_hold : '0;
      out_velocity    <= granted ? vel_hold : '0;
      active_count    <= (int'(fin.act) > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(fin.act);
      releasing_count <= (int'(fin.rel) > int'(COUNT_MAX)) ? COUNT_MAX : COUNT_W'(fin.rel);
    end
  end

endmodule
`default_nettype wire
